// ===== sv/base64_codec_assert.svh =====
// assertion macros for the base64 codec
// no dependencies; included by the top level, which supplies clk and arst_n
`ifndef BASE64_CODEC_ASSERT_SVH
`define BASE64_CODEC_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define B64C_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked outside reset
`define B64C_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define B64C_ASSERT_NOW(label, ante, cons, msg)
`define B64C_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== sv/b64c_pkg.sv =====
// package for the base64 codec: word types, register map, alphabet functions
// no dependencies; used by base64_codec
package b64c_pkg;

	// register map
	localparam int unsigned AddrWidth = 3;
	localparam logic [AddrWidth-1:0] RegModeAddr = 3'd0;

	// mode codes
	localparam logic ModeEncode = 1'b0;
	localparam logic ModeDecode = 1'b1;

	localparam logic [7:0] PadChar = 8'h3d;

	// most results one input word can cause
	localparam int unsigned MaxResults = 4;

	typedef struct packed {
		logic [7:0] in_symbol;
		logic       in_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_symbol;
		logic       out_last;
		logic       out_empty;
	} out_word_t;

	// sextet to alphabet character
	function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h61 + {2'b00, v - 6'd26};
		end else if (v < 6'd62) begin
			c = 8'h30 + {2'b00, v - 6'd52};
		end else if (v == 6'd62) begin
			c = 8'h2b;
		end else begin
			c = 8'h2f;
		end
		return c;
	endfunction

	// character to {valid, sextet}
	function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
		logic [6:0] r;
		if (c >= 8'h41 && c <= 8'h5a) begin
			r = {1'b1, 6'(c - 8'h41)};
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			r = {1'b1, 6'(c - 8'h61 + 8'd26)};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 6'(c - 8'h30 + 8'd52)};
		end else if (c == 8'h2b) begin
			r = {1'b1, 6'd62};
		end else if (c == 8'h2f) begin
			r = {1'b1, 6'd63};
		end else begin
			r = 7'd0;
		end
		return r;
	endfunction

endpackage

// ===== sv/base64_codec.sv =====
// base64 codec top level: input register, group logic, result shift buffer
// depends on b64c_pkg and base64_codec_assert.svh
//
// Usage
// - input channel in_valid/in_ready/in_data carries one symbol per word with a
//   last flag; output channel out_valid/out_ready/out_data gives one symbol per
//   word, with out_last on the final word of a message and out_empty on a
//   marker word that closes a message with nothing left to give
// - mode register at byte address 0 (APB, pready always high): 0 encodes,
//   1 decodes; a write also drops any partial group
// - an accepted word is held in the input register; its results are loaded
//   into the result buffer, and so reach out_data, once the buffer is free
// - throughput: one result word per cycle from the four-entry result buffer
//   while it holds results and out_ready is high; a word leaves the input
//   register only once the buffer is empty or sends its final word, even when
//   it gives no result; encoding gives four results per three input words and
//   decoding three results per four input words
// - the input register takes one more word while the result buffer still
//   holds unsent results, so a stalled receiver does not stall the sender
//   until both are full
// - reset clears the mode to encode, the partial group and both buffers
module base64_codec
	import b64c_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input word channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_word_t             in_data,
	// result word channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_word_t            out_data,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int unsigned CntWidth = $clog2(MaxResults + 1);

	// registers
	logic                mode_q;
	logic [17:0]         grp_bits_q;
	logic [1:0]          grp_cnt_q;
	logic                stopped_q;
	logic                valid_s1;
	in_word_t            word_s1;
	logic [7:0]          buf_q [MaxResults];
	logic [CntWidth-1:0] cnt_q;
	logic                last_q;
	logic                empty_q;

	// combinational results of the group logic
	logic [7:0]          res_sym [MaxResults];
	logic [CntWidth-1:0] res_cnt;
	logic                res_empty;
	logic [17:0]         nxt_bits;
	logic [1:0]          nxt_cnt;
	logic                nxt_stopped;

	logic cfg_wr;
	logic move;
	logic pop;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == RegModeAddr);
	assign prdata = (paddr == RegModeAddr) ? {31'd0, mode_q} : 32'd0;

	// handshakes
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign move      = valid_s1 && ((cnt_q == '0) || ((cnt_q == CntWidth'(1)) && out_ready));
	assign in_ready  = !valid_s1 || move;

	assign out_data.out_symbol = buf_q[0];
	assign out_data.out_last   = last_q && (cnt_q == CntWidth'(1));
	assign out_data.out_empty  = empty_q;

	// group logic for the word in the input register
	always_comb begin
		logic [23:0] acc;
		logic [23:0] full;
		logic [2:0]  n;
		logic [6:0]  dec;
		for (int i = 0; i < MaxResults; i++) begin
			res_sym[i] = 8'd0;
		end
		res_cnt     = '0;
		res_empty   = 1'b0;
		nxt_bits    = grp_bits_q;
		nxt_cnt     = grp_cnt_q;
		nxt_stopped = stopped_q;
		acc         = 24'd0;
		full        = 24'd0;
		n           = 3'd0;
		dec         = char_to_sextet(word_s1.in_symbol);
		if (mode_q == ModeEncode) begin
			// encode: gather bytes, emit four characters per group
			acc = {grp_bits_q[15:0], word_s1.in_symbol};
			n   = {1'b0, grp_cnt_q} + 3'd1;
			if (n > 3'd3) begin
				n = 3'd3;
			end
			if (n == 3'd3 || word_s1.in_last) begin
				case (n)
					3'd1:    full = {acc[7:0], 16'd0};
					3'd2:    full = {acc[15:0], 8'd0};
					default: full = acc;
				endcase
				for (int i = 0; i < 4; i++) begin
					if (3'(i) <= n) begin
						res_sym[i] = sextet_to_char(full[23-6*i -: 6]);
					end else begin
						res_sym[i] = PadChar;
					end
				end
				res_cnt  = CntWidth'(4);
				nxt_bits = 18'd0;
				nxt_cnt  = 2'd0;
			end else begin
				nxt_bits = {2'b00, acc[15:0]};
				nxt_cnt  = n[1:0];
			end
		end else begin
			// decode: gather sextets until a stop character
			acc = {6'd0, grp_bits_q};
			n   = {1'b0, grp_cnt_q};
			if (!stopped_q) begin
				if (dec[6]) begin
					acc = {acc[17:0], dec[5:0]};
					n   = n + 3'd1;
				end else begin
					nxt_stopped = 1'b1;
				end
			end
			if (n == 3'd4) begin
				res_sym[0] = acc[23:16];
				res_sym[1] = acc[15:8];
				res_sym[2] = acc[7:0];
				res_cnt    = CntWidth'(3);
				acc        = 24'd0;
				n          = 3'd0;
			end
			// flush of a partial group at message end
			if (word_s1.in_last && n != 3'd0) begin
				case (n)
					3'd1:    full = {acc[5:0], 18'd0};
					3'd2:    full = {acc[11:0], 12'd0};
					default: full = {acc[17:0], 6'd0};
				endcase
				if (n >= 3'd2) begin
					res_sym[0] = full[23:16];
					res_cnt    = CntWidth'(1);
				end
				if (n == 3'd3) begin
					res_sym[1] = full[15:8];
					res_cnt    = CntWidth'(2);
				end
				acc = 24'd0;
				n   = 3'd0;
			end
			nxt_bits = acc[17:0];
			nxt_cnt  = n[1:0];
		end
		// message end clears the group; empty marker when nothing to give
		if (word_s1.in_last) begin
			nxt_bits    = 18'd0;
			nxt_cnt     = 2'd0;
			nxt_stopped = 1'b0;
			if (res_cnt == '0) begin
				res_sym[0] = 8'd0;
				res_cnt    = CntWidth'(1);
				res_empty  = 1'b1;
			end
		end
	end

	// mode and group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= ModeEncode;
			grp_bits_q <= 18'd0;
			grp_cnt_q  <= 2'd0;
			stopped_q  <= 1'b0;
		end else if (cfg_wr) begin
			mode_q     <= pwdata[0];
			grp_bits_q <= 18'd0;
			grp_cnt_q  <= 2'd0;
			stopped_q  <= 1'b0;
		end else if (move) begin
			grp_bits_q <= nxt_bits;
			grp_cnt_q  <= nxt_cnt;
			stopped_q  <= nxt_stopped;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_data;
		end
	end

	// result buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			last_q  <= 1'b0;
			empty_q <= 1'b0;
		end else if (move) begin
			cnt_q   <= res_cnt;
			last_q  <= word_s1.in_last;
			empty_q <= res_empty;
		end else if (pop) begin
			cnt_q <= cnt_q - CntWidth'(1);
		end
	end

	// result buffer data, shifted one word per pop
	always_ff @(posedge clk) begin
		if (move) begin
			buf_q <= res_sym;
		end else if (pop) begin
			for (int i = 0; i < MaxResults - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
			buf_q[MaxResults-1] <= 8'd0;
		end
	end

	// checks
`include "base64_codec_assert.svh"
	`B64C_ASSERT_NOW(a_empty_is_last, out_valid && out_data.out_empty, out_data.out_last, "empty marker without last")
	`B64C_ASSERT_NEXT(a_last_gives_result, move && word_s1.in_last, out_valid, "message end gave no result")
	`B64C_ASSERT_NOW(a_enc_count, mode_q == ModeEncode, grp_cnt_q != 2'd3, "encode group overfull")
	`B64C_ASSERT_NOW(a_buf_bound, 1'b1, cnt_q <= CntWidth'(MaxResults), "result buffer overrun")

endmodule

// ===== test/base64_codec_tb.sv =====
// testbench for base64_codec: directed and random encode/decode messages checked word by word
// depends on b64c_pkg and the base64_codec rtl; stands alone otherwise
module base64_codec_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import b64c_pkg::*;

	localparam int CycleLimit = 300000;
	localparam int DrainCycles = 12;
	localparam int StallCycles = 300;
	localparam int RandomWords = 300;
	// an address with no register behind it
	localparam logic [AddrWidth-1:0] RegUnusedAddr = 3'd4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [AddrWidth-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// codec state as the testbench sees it
	string b64_letters = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	logic cur_mode = ModeEncode;
	logic [17:0] grp_bits = '0;
	logic [1:0] grp_cnt = '0;
	logic dec_stopped = 1'b0;
	out_word_t awaited_words[$];
	out_word_t head_word;

	// run bookkeeping
	int fail_count = 0;
	int words_sent = 0;
	int ignored_words = 0;
	int messages_closed = 0;
	int results_checked = 0;
	int reg_writes = 0;
	int cycle_count = 0;
	bit steady = 1'b0;
	int stall_request = 0;
	int hold_left = 0;

	base64_codec u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("base64_codec_tb: FAIL");
			$finish;
		end
	end

	// receiver: random stalls, steady stretches and one long hold-off
	always @(negedge clk) begin
		if (stall_request != 0) begin
			hold_left = stall_request;
			stall_request = 0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (steady) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 20);
		end
	end

	// compare each result word with the oldest awaited one
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_words.size() == 0) begin
				$error("result word %h arrived with nothing awaited", out_data);
				fail_count++;
			end else begin
				head_word = awaited_words.pop_front();
				if (out_data.out_symbol !== head_word.out_symbol) begin
					$error("out_symbol: expected %h, got %h", head_word.out_symbol,
						out_data.out_symbol);
					fail_count++;
				end
				if (out_data.out_last !== head_word.out_last) begin
					$error("out_last: expected %b, got %b", head_word.out_last,
						out_data.out_last);
					fail_count++;
				end
				if (out_data.out_empty !== head_word.out_empty) begin
					$error("out_empty: expected %b, got %b", head_word.out_empty,
						out_data.out_empty);
					fail_count++;
				end
				results_checked++;
			end
		end
	end

	function automatic out_word_t symbol_word(input logic [7:0] c);
		out_word_t w;
		w.out_symbol = c;
		w.out_last = 1'b0;
		w.out_empty = 1'b0;
		return w;
	endfunction

	// alphabet position of a character, 64 when it is not a base64 letter
	function automatic int sextet_index(input logic [7:0] c);
		for (int i = 0; i < 64; i++)
			if (b64_letters[i] == c)
				return i;
		return 64;
	endfunction

	// one accepted word through the codec: queue the result words it gives
	task automatic base64_step(input logic [7:0] sym, input logic last);
		out_word_t res[$];
		out_word_t marker;
		logic [23:0] acc;
		logic [23:0] full;
		int n;
		int v;
		if (cur_mode == ModeEncode) begin
			acc = {grp_bits[15:0], sym};
			n = grp_cnt + 1;
			if (n >= 3 || last) begin
				full = acc << (8 * (3 - n));
				for (int i = 0; i <= n; i++)
					res = {res, symbol_word(b64_letters[full[23 - 6 * i -: 6]])};
				for (int i = n; i < 3; i++)
					res = {res, symbol_word(PadChar)};
				grp_bits = '0;
				grp_cnt = '0;
			end else begin
				grp_bits = {2'b00, acc[15:0]};
				grp_cnt = n[1:0];
			end
		end else begin
			acc = {6'b0, grp_bits};
			n = grp_cnt;
			if (dec_stopped) begin
				ignored_words++;
			end else begin
				v = sextet_index(sym);
				if (v < 64) begin
					acc = {acc[17:0], v[5:0]};
					n++;
				end else begin
					dec_stopped = 1'b1;
				end
			end
			// full group of four letters
			if (n == 4) begin
				res = {res, symbol_word(acc[23:16])};
				res = {res, symbol_word(acc[15:8])};
				res = {res, symbol_word(acc[7:0])};
				acc = '0;
				n = 0;
			end
			// partial group flushed at message end
			if (last && n > 0) begin
				full = acc << (6 * (4 - n));
				for (int i = 0; i + 1 < n; i++)
					res = {res, symbol_word(full[23 - 8 * i -: 8])};
				acc = '0;
				n = 0;
			end
			grp_bits = acc[17:0];
			grp_cnt = n[1:0];
		end
		// message end: close with the last word or an empty marker
		if (last) begin
			grp_bits = '0;
			grp_cnt = '0;
			dec_stopped = 1'b0;
			messages_closed++;
			if (res.size() == 0) begin
				marker.out_symbol = 8'h00;
				marker.out_last = 1'b1;
				marker.out_empty = 1'b1;
				res = {res, marker};
			end else begin
				res[res.size() - 1].out_last = 1'b1;
			end
		end
		foreach (res[i])
			awaited_words = {awaited_words, res[i]};
	endtask

	// offer one word, holding it until accepted; entered and left at a falling edge
	task automatic offer_word(input logic [7:0] sym, input logic last);
		while (!steady && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{in_symbol: sym, in_last: last};
		do
			@(posedge clk);
		while (!in_ready);
		base64_step(sym, last);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_message(input logic [7:0] msg[$], input logic closed);
		foreach (msg[i])
			offer_word(msg[i], closed && (i == msg.size() - 1));
	endtask

	// wait for every awaited word, then for words that give no result to pass
	task automatic settle();
		in_valid <= 1'b0;
		while (awaited_words.size() != 0)
			@(negedge clk);
		repeat (DrainCycles)
			@(negedge clk);
	endtask

	// register write: setup then access cycle, then back to idle
	task automatic write_reg(input logic [AddrWidth-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr == RegModeAddr) begin
			cur_mode = data[0];
			grp_bits = '0;
			grp_cnt = '0;
			dec_stopped = 1'b0;
		end
		reg_writes++;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_mode_reg();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= RegModeAddr;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {31'b0, cur_mode}) begin
			$error("mode: expected %0d, got %0d", cur_mode, prdata);
			fail_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	function automatic void build_plain(output logic [7:0] msg[$]);
		msg = {};
		repeat ($urandom_range(1, 9))
			msg = {msg, 8'($urandom_range(255))};
	endfunction

	// mostly well-formed text, some with padding, a fifth with stray bytes
	function automatic void build_text(output logic [7:0] msg[$]);
		int kind;
		int tail;
		msg = {};
		kind = $urandom_range(99);
		tail = $urandom_range(3);
		repeat (4 * $urandom_range(3) + tail)
			msg = {msg, 8'(b64_letters[$urandom_range(63)])};
		if (kind < 40 && tail >= 2)
			repeat (4 - tail)
				msg = {msg, PadChar};
		if (kind >= 80) begin
			msg.insert($urandom_range(msg.size()), 8'($urandom_range(255)));
			repeat ($urandom_range(2))
				msg = {msg, 8'($urandom_range(255))};
		end
		if (msg.size() == 0)
			msg = {msg, 8'(b64_letters[$urandom_range(63)])};
	endfunction

	// mode register: reset value, unused address, full-width write, read back
	task automatic test_register_access();
		check_mode_reg();
		write_reg(RegUnusedAddr, 32'h0000_0001);
		check_mode_reg();
		write_reg(RegModeAddr, 32'hffff_ffff);
		check_mode_reg();
		write_reg(RegModeAddr, {31'b0, ModeEncode});
		check_mode_reg();
	endtask

	// encode: one and two byte tails with padding, a full group hitting '+' and '/'
	task automatic test_encode_groups();
		write_reg(RegModeAddr, {31'b0, ModeEncode});
		send_message('{8'h00}, 1'b1);
		send_message('{8'hff, 8'h80}, 1'b1);
		send_message('{8'hfb, 8'hff, 8'hbf}, 1'b1);
		settle();
	endtask

	// decode: full group, padded tail, single letter, stray byte, lone pad
	task automatic test_decode_groups();
		write_reg(RegModeAddr, {31'b0, ModeDecode});
		// "TWFu"
		send_message('{8'h54, 8'h57, 8'h46, 8'h75}, 1'b1);
		// "QQ=="
		send_message('{8'h51, 8'h51, 8'h3d, 8'h3d}, 1'b1);
		// "Z" on its own gives no byte
		send_message('{8'h5a}, 1'b1);
		// "a", stray 0xff, "b"
		send_message('{8'h61, 8'hff, 8'h62}, 1'b1);
		send_message('{PadChar}, 1'b1);
		settle();
	endtask

	// a mode write drops the half-built group
	task automatic test_mode_change_mid_message();
		write_reg(RegModeAddr, {31'b0, ModeEncode});
		send_message('{8'hc3, 8'h5a}, 1'b0);
		settle();
		write_reg(RegModeAddr, {31'b0, ModeDecode});
		send_message('{8'h54, 8'h57, 8'h46, 8'h75}, 1'b1);
		settle();
	endtask

	// long output hold-off while the sender keeps pushing
	task automatic test_backpressure();
		logic [7:0] msg[$];
		write_reg(RegModeAddr, {31'b0, ModeEncode});
		stall_request = StallCycles;
		repeat (8) begin
			msg = {};
			repeat (5)
				msg = {msg, 8'($urandom_range(255))};
			send_message(msg, 1'b1);
		end
		settle();
	endtask

	// random phases, each with its own mode write
	task automatic test_random_messages();
		logic [7:0] msg[$];
		int phase;
		int start_count;
		phase = 0;
		start_count = words_sent - ignored_words;
		while ((words_sent - ignored_words) - start_count < RandomWords) begin
			steady = (phase == 3);
			write_reg(RegModeAddr,
				{31'b0, (phase < 2) ? phase[0] : 1'($urandom_range(1))});
			repeat ($urandom_range(3, 8)) begin
				if (cur_mode == ModeEncode)
					build_plain(msg);
				else
					build_text(msg);
				send_message(msg, 1'b1);
			end
			// sometimes leave a message open for the next mode write to drop
			if ($urandom_range(3) == 0) begin
				if (cur_mode == ModeEncode)
					build_plain(msg);
				else
					build_text(msg);
				send_message(msg, 1'b0);
			end
			settle();
			phase++;
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_register_access();
		test_encode_groups();
		test_decode_groups();
		test_mode_change_mid_message();
		test_backpressure();
		test_random_messages();
		settle();

		$display("covered %0d input words in %0d messages, %0d result words checked",
			words_sent, messages_closed, results_checked);
		$display("%0d register writes over both modes, with a %0d-cycle output hold-off",
			reg_writes, StallCycles);
		if (fail_count == 0) begin
			$display("base64_codec_tb: PASS");
		end else begin
			$display("base64_codec_tb: FAIL");
		end
		$finish;
	end

endmodule
